/* hdl/rle_terrain_map_decoder_macros.svh */
// Assertion macros for the terrain map run-length decoder.
// Used by rle_terrain_map_decoder.sv; expects clk and rst_n in scope.
`ifndef RLE_TERRAIN_MAP_DECODER_MACROS_SVH
`define RLE_TERRAIN_MAP_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RTMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtmd same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RTMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtmd next-cycle check failed");

`endif

/* hdl/rtmd_pkg.sv */
// Shared types, constants and the terrain translation table for the decoder.
// No dependencies; imported by the channel interfaces and the top level.
package rtmd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TERRAIN_W = 5;
  localparam int unsigned RUN_W     = 10;
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned SKIP_W    = 13;

  localparam logic [BYTE_W-1:0] MARK_BYTE    = 8'hff;
  localparam logic [BYTE_W-1:0] SYM_MASK     = 8'hfc;
  localparam logic [BYTE_W-1:0] RUN_LOW_MASK = 8'h03;
  localparam int unsigned       HDR_UNIT     = 20;
  localparam int unsigned       HDR_BASE     = 4;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_SKIP = 2'd1,
    PH_LOW  = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  // Symbol (6 bits) to terrain code
  function automatic logic [TERRAIN_W-1:0] terrain_of(input logic [5:0] sym);
    logic [TERRAIN_W-1:0] code;
    case (sym) inside
      6'd1, 6'd2, 6'd10:   code = 5'd1;
      6'd3:                code = 5'd3;
      6'd4, [6'd27:6'd32]: code = 5'd5;
      6'd5, 6'd26:         code = 5'd6;
      6'd6:                code = 5'd7;
      6'd7:                code = 5'd14;
      6'd8:                code = 5'd12;
      6'd9:                code = 5'd13;
      [6'd11:6'd18]:       code = 5'd4;
      6'd19:               code = 5'd17;
      6'd24, 6'd25:        code = 5'd2;
      default:             code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

/* hdl/rtmd_channels_if.sv */
// Valid/ready channel interfaces: map bytes in, run records out, config writes.
// Depends on rtmd_pkg for field widths.
interface rtmd_byte_if
  import rtmd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] map_byte;
  logic              first;
  modport source (output valid, output map_byte, output first, input ready);
  modport sink   (input valid, input map_byte, input first, output ready);
endinterface

interface rtmd_run_if
  import rtmd_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [TERRAIN_W-1:0] terrain;
  logic [RUN_W-1:0]     run_length;
  logic                 overrun;
  logic                 last;
  modport source (output valid, output terrain, output run_length, output overrun,
                  output last, input ready);
  modport sink   (input valid, input terrain, input run_length, input overrun,
                  input last, output ready);
endinterface

interface rtmd_cfg_if
  import rtmd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rle_terrain_map_decoder.sv */
// Terrain collision map run-length decoder, top level.
// Depends on rtmd_pkg, rtmd_channels_if.sv and rle_terrain_map_decoder_macros.svh.
//
//   channel  | dir | carries                                  | transaction when
//   in_if    | in  | map_byte[7:0], first                     | valid && ready
//   out_if   | out | terrain[4:0], run_length[9:0], overrun, last | valid && ready
//   cfg_if   | in  | data[23:0] = pixel_total                 | valid && ready
//
// One map byte is taken per cycle while in_if.ready is high; a run record appears
// in the output register the cycle after the byte that completes its pair.
// The byte path is one pass of counter, compare and table logic into that register.
// in_if.ready drops only while a record sits in the output register untaken.
// cfg_if.ready is always high. Reset (rst_n low, synchronous) clears the phase,
// counters, pixel_total and the output valid.
`include "rle_terrain_map_decoder_macros.svh"

module rle_terrain_map_decoder
  import rtmd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  rtmd_byte_if.sink   in_if,
  rtmd_run_if.source  out_if,
  rtmd_cfg_if.sink    cfg_if
);

  phase_t               phase_r, phase_nxt;
  logic [SKIP_W-1:0]    skip_left_r, skip_left_nxt;
  logic [BYTE_W-1:0]    held_r, held_nxt;
  logic [PIX_W-1:0]     pixels_done_r, pixels_done_nxt;
  logic [PIX_W-1:0]     pixel_total_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [TERRAIN_W-1:0] terrain_r, terrain_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic                 overrun_r, overrun_nxt;
  logic                 last_r, last_nxt;

  logic                 in_acc;
  logic                 out_load;
  logic [PIX_W-1:0]     left;
  logic [RUN_W-1:0]     run_raw;
  logic [SKIP_W-1:0]    hdr_count;

  // Take a byte whenever the output register is free or being emptied
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Header length n*20 + 3 further bytes, as shifts and adds
  assign hdr_count = ({5'd0, in_if.map_byte} << 4) + ({5'd0, in_if.map_byte} << 2)
                   + SKIP_W'(HDR_BASE - 1);
  assign left      = pixel_total_r - pixels_done_r;
  assign run_raw   = {in_if.map_byte, held_r[1:0] & RUN_LOW_MASK[1:0]};

  // Next state and result
  always_comb begin
    phase_nxt       = phase_r;
    skip_left_nxt   = skip_left_r;
    held_nxt        = held_r;
    pixels_done_nxt = pixels_done_r;
    out_load        = 1'b0;
    terrain_nxt     = terrain_r;
    run_nxt         = run_r;
    overrun_nxt     = overrun_r;
    last_nxt        = last_r;
    if (in_acc) begin
      if (in_if.first) begin
        pixels_done_nxt = '0;
        held_nxt        = '0;
        skip_left_nxt   = hdr_count;
        phase_nxt       = (hdr_count != '0) ? PH_SKIP : PH_LOW;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            skip_left_nxt = skip_left_r - 1'b1;
            if (skip_left_nxt == '0) phase_nxt = PH_LOW;
          end
          PH_LOW: begin
            held_nxt  = in_if.map_byte;
            phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            if (pixels_done_r >= pixel_total_r) begin
              phase_nxt = PH_DONE;
            end else if (held_r == MARK_BYTE && in_if.map_byte == MARK_BYTE) begin
              // end-of-map marker record
              phase_nxt   = PH_DONE;
              out_load    = 1'b1;
              terrain_nxt = '0;
              run_nxt     = '0;
              overrun_nxt = 1'b0;
              last_nxt    = 1'b1;
            end else begin
              out_load    = 1'b1;
              terrain_nxt = terrain_of(6'((held_r & SYM_MASK) >> 2));
              if ({{(PIX_W-RUN_W){1'b0}}, run_raw} > left) begin
                run_nxt     = left[RUN_W-1:0];
                overrun_nxt = 1'b1;
              end else begin
                run_nxt     = run_raw;
                overrun_nxt = 1'b0;
              end
              pixels_done_nxt = pixels_done_r + {{(PIX_W-RUN_W){1'b0}}, run_nxt};
              last_nxt        = ({{(PIX_W-RUN_W){1'b0}}, run_nxt} == left);
              phase_nxt       = last_nxt ? PH_DONE : PH_LOW;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
    out_valid_nxt = out_load || (out_valid_r && !out_if.ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_DONE;
      skip_left_r   <= '0;
      held_r        <= '0;
      pixels_done_r <= '0;
      pixel_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      skip_left_r   <= skip_left_nxt;
      held_r        <= held_nxt;
      pixels_done_r <= pixels_done_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) pixel_total_r <= cfg_if.data;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    terrain_r <= terrain_nxt;
    run_r     <= run_nxt;
    overrun_r <= overrun_nxt;
    last_r    <= last_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.terrain    = terrain_r;
  assign out_if.run_length = run_r;
  assign out_if.overrun    = overrun_r;
  assign out_if.last       = last_r;

  // Checks
  `RTMD_ASSERT_NOW(a_clip_is_last, out_load && overrun_nxt, last_nxt)
  `RTMD_ASSERT_NEXT(a_last_stops, out_load && last_nxt, phase_r == PH_DONE)
  `RTMD_ASSERT_NEXT(a_done_holds, phase_r == PH_DONE && !(in_acc && in_if.first),
                    phase_r == PH_DONE)
  `RTMD_ASSERT_NOW(a_skip_nonzero, phase_r == PH_SKIP, skip_left_r != '0)

endmodule
